### hdl/sha256_pkg.sv
// ============================================================================
// SHA-256 package
// Shared constants, types and round functions of the SHA-256 hash engine.
// ============================================================================
package sha256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned HashWords  = 8;
    localparam int unsigned WinWords   = 16;
    localparam int unsigned LenBytePos = 56;
    localparam logic [7:0]  PadByte    = 8'h80;

    typedef enum logic [0:0] {
        MODE_DATA   = 1'b0,
        MODE_FINISH = 1'b1
    } t_mode;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } t_out;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_in;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h [0:7];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

### hdl/sha256_if.sv
// ============================================================================
// SHA-256 request channels
// Valid/ready channels for input and digest requests.
// ============================================================================
interface sha256_in_if;
    logic              valid;
    logic              ready;
    sha256_pkg::t_in   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
    logic              valid;
    logic              ready;
    sha256_pkg::t_out  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hdl/sha256_hash_engine_top.sv
// ============================================================================
// SHA-256 hash engine
// Byte-serial SHA-256 with block buffer and message schedule in synchronous
// memories, one compression round per cycle.
// ============================================================================
// A byte that fills a block starts a compression (load, 64 rounds, hash update),
// done by the single round unit; no request is taken until it is done.
// A finish request pads the rest of the block and compresses it, and pads and
// compresses a second block when the pad byte lands at byte 56 or later.
// After the S_OUT state eight digest words follow, one per cycle while ready is high.
// Synchronous active-low reset restores the initial hash and zero length.
module sha256_hash_engine_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sha256_in_if.sink    i_in,
    sha256_out_if.source o_out
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_ROUND = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_WAIT  = 7'b1000000
    } t_state;

    t_state       r_state, n_state;
    logic [31:0]  r_hash [0:7];
    logic [31:0]  r_var [0:7];
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic [63:0]  r_len;
    logic         r_finish;
    logic         r_mark;
    logic         r_lenblk;
    logic [6:0]   r_t;
    logic [2:0]   r_oidx;

    logic [31:0]  r_blk [0:15];
    logic [31:0]  r_win [0:15];
    logic [31:0]  r_blk_q;
    logic [31:0]  r_w2_q, r_w7_q, r_w15_q, r_w16_q;

    logic         blk_we;
    logic [5:0]   blk_wa;
    logic [7:0]   blk_wd;
    logic         acc_in;
    logic [7:0]   pad_byte;
    logic [31:0]  w_cur, t1, t2;
    logic [5:0]   rnd;

    assign acc_in   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign rnd      = r_t[5:0] - 6'd1;

    // The length goes into the block where the pad byte left room for it.
    always_comb begin
        pad_byte = 8'h00;
        if (!r_mark) begin
            pad_byte = sha256_pkg::PadByte;
        end else if (r_lenblk && r_fill >= 6'(sha256_pkg::LenBytePos)) begin
            pad_byte = r_len[{~r_fill[2:0], 3'b000} +: 8];
        end
    end

    // Block buffer: written one byte a cycle, read one 32-bit word a cycle.
    always_comb begin
        blk_we = 1'b0;
        blk_wa = r_fill;
        blk_wd = i_in.payload.data_byte;
        if (r_state == S_IDLE && acc_in && i_in.payload.mode == sha256_pkg::MODE_DATA) begin
            blk_we = 1'b1;
        end else if (r_state == S_PAD) begin
            blk_we = 1'b1;
            blk_wd = pad_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            r_blk[blk_wa[5:2]][{~blk_wa[1:0], 3'b000} +: 8] <= blk_wd;
        end
        r_blk_q <= r_blk[r_t[3:0]];
    end

    // Schedule window: W[t] comes from words registered in the cycle before round t.
    logic [31:0] w_new;
    logic [3:0]  win_wa;
    logic        win_we;
    assign w_new = sha256_pkg::ssig1(r_w2_q) + r_w7_q + sha256_pkg::ssig0(r_w15_q) + r_w16_q;

    always_comb begin
        win_we = 1'b0;
        win_wa = rnd[3:0];
        w_cur  = r_blk_q;
        if (r_state == S_ROUND) begin
            win_we = 1'b1;
            w_cur  = (rnd < 6'd16) ? r_blk_q : w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_we) begin
            r_win[win_wa] <= w_cur;
        end
        r_w2_q  <= (win_we && win_wa == r_t[3:0] - 4'd2) ? w_cur : r_win[r_t[3:0] - 4'd2];
        r_w7_q  <= (win_we && win_wa == r_t[3:0] - 4'd7) ? w_cur : r_win[r_t[3:0] - 4'd7];
        r_w15_q <= (win_we && win_wa == r_t[3:0] - 4'd15) ? w_cur : r_win[r_t[3:0] - 4'd15];
        r_w16_q <= (win_we && win_wa == r_t[3:0]) ? w_cur : r_win[r_t[3:0]];
    end

    assign t1 = r_var[7] + sha256_pkg::bsig1(r_var[4])
              + ((r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]))
              + sha256_pkg::round_k(rnd) + w_cur;
    assign t2 = sha256_pkg::bsig0(r_var[0])
              + ((r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    if (i_in.payload.mode == sha256_pkg::MODE_FINISH) begin
                        n_state = S_PAD;
                    end else if (r_fill == 6'd63) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_PAD:   n_state = (r_fill == 6'd63) ? S_LOAD : S_PAD;
            S_LOAD:  n_state = S_ROUND;
            S_ROUND: n_state = (r_t == 7'(sha256_pkg::Rounds)) ? S_ADD : S_ROUND;
            S_ADD: begin
                if (r_finish && r_lenblk) begin
                    n_state = S_OUT;
                end else if (r_finish) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT:   n_state = S_WAIT;
            S_WAIT:  n_state = (o_out.ready && r_oidx == 3'd7) ? S_IDLE : S_WAIT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_finish <= 1'b0;
            r_mark   <= 1'b1;
            r_lenblk <= 1'b0;
            r_t      <= '0;
            r_oidx   <= '0;
            r_len    <= '0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= sha256_pkg::init_hash(3'(i));
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_t <= '0;
                    if (acc_in) begin
                        if (i_in.payload.mode == sha256_pkg::MODE_FINISH) begin
                            r_finish <= 1'b1;
                            r_mark   <= 1'b0;
                            r_lenblk <= (r_fill < 6'(sha256_pkg::LenBytePos));
                            r_len    <= r_bits;
                            r_oidx   <= '0;
                        end else begin
                            r_fill <= r_fill + 6'd1;
                            r_bits <= r_bits + 64'd8;
                        end
                    end
                end
                S_PAD: begin
                    r_fill <= r_fill + 6'd1;
                    r_t    <= '0;
                    r_mark <= 1'b1;
                end
                S_LOAD: begin
                    r_t <= 7'd1;
                    for (int i = 0; i < 8; i++) begin
                        r_var[i] <= r_hash[i];
                    end
                end
                S_ROUND: begin
                    r_t <= r_t + 7'd1;
                    r_var[7] <= r_var[6];
                    r_var[6] <= r_var[5];
                    r_var[5] <= r_var[4];
                    r_var[4] <= r_var[3] + t1;
                    r_var[3] <= r_var[2];
                    r_var[2] <= r_var[1];
                    r_var[1] <= r_var[0];
                    r_var[0] <= t1 + t2;
                end
                S_ADD: begin
                    r_t <= '0;
                    if (r_finish) begin
                        r_lenblk <= 1'b1;
                    end
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i] <= r_hash[i] + r_var[i];
                    end
                end
                S_OUT: begin
                    r_oidx <= '0;
                end
                S_WAIT: begin
                    if (o_out.ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_finish <= 1'b0;
                            r_fill   <= '0;
                            r_bits   <= '0;
                            r_len    <= '0;
                            for (int i = 0; i < 8; i++) begin
                                r_hash[i] <= sha256_pkg::init_hash(3'(i));
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid               = (r_state == S_WAIT);
    assign o_out.payload.digest_word = r_hash[r_oidx];
    assign o_out.payload.word_index  = r_oidx;
    assign o_out.payload.last        = (r_oidx == 3'd7);

endmodule

### tb/tb_sha256_hash_engine_top.sv
// ============================================================================
// SHA-256 hash engine testbench
// Feeds byte and finish requests, some messages at random pace, predicts every digest word
// with an independent SHA-256 model and checks each output request in order.
// ============================================================================
module tb_sha256_hash_engine_top;

    class digest_scoreboard;
        logic [31:0] hash_st [8];
        logic [7:0]  blk [64];
        int          fill;
        logic [63:0] nbits;
        sha256_pkg::t_out pending [$];
        int          errors;
        int          checked;

        function new();
            errors = 0;
            checked = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) begin
                hash_st[i] = sha256_pkg::init_hash(i[2:0]);
            end
            fill = 0;
            nbits = '0;
        endfunction

        function logic [31:0] rr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2, s0, s1;
            for (int i = 0; i < 16; i++) begin
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            end
            for (int t = 16; t < 64; t++) begin
                s0 = rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = s1 + w[t-7] + s0 + w[t-16];
            end
            for (int i = 0; i < 8; i++) begin
                v[i] = hash_st[i];
            end
            for (int t = 0; t < 64; t++) begin
                t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(t[5:0]) + w[t];
                t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                for (int i = 7; i > 0; i--) begin
                    v[i] = v[i-1];
                end
                v[4] = v[4] + t1;
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) begin
                hash_st[i] = hash_st[i] + v[i];
            end
        endfunction

        function void push_byte(logic [7:0] b);
            blk[fill] = b;
            fill++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        endfunction

        function void note_request(sha256_pkg::t_in req);
            logic [63:0] len;
            sha256_pkg::t_out o;
            if (req.mode == sha256_pkg::MODE_DATA) begin
                push_byte(req.data_byte);
                nbits = nbits + 64'd8;
            end else begin
                len = nbits;
                push_byte(sha256_pkg::PadByte);
                while (fill != sha256_pkg::LenBytePos) begin
                    push_byte(8'h00);
                end
                for (int i = 0; i < 8; i++) begin
                    push_byte(len[63-8*i -: 8]);
                end
                for (int i = 0; i < 8; i++) begin
                    o.digest_word = hash_st[i];
                    o.word_index = i[2:0];
                    o.last = (i == 7);
                    pending = {pending, o};
                end
                restart();
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_result(sha256_pkg::t_out got);
            sha256_pkg::t_out want;
            if (pending.size() == 0) begin
                report("unexpected digest word", got.digest_word, 32'd0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.digest_word !== want.digest_word)
                report("digest_word", got.digest_word, want.digest_word);
            if (got.word_index !== want.word_index)
                report("word_index", 32'(got.word_index), 32'(want.word_index));
            if (got.last !== want.last)
                report("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    sha256_in_if  in_ch();
    sha256_out_if out_ch();
    digest_scoreboard sb = new();
    int idle_cycles = 0;
    int sent_msgs = 0;
    int out_wait = 0;
    bit stall_mode = 1'b1;
    localparam int Watchdog = 20000;

    always #5 i_clk = ~i_clk;

    sha256_hash_engine_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_request(in_ch.payload);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.payload);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= Watchdog) begin
                $display("watchdog expired");
                $display("sha256_hash_engine_top regression: fail");
                $finish;
            end
        end
    end

    // After each accepted digest word the sink may drop ready for a random wait while stall_mode is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_wait = 0;
        end else if (out_ch.valid && out_ch.ready) begin
            out_wait = stall_mode ? $urandom_range(0, 15) : 0;
            out_ch.ready <= (out_wait == 0);
        end else if (out_wait > 0) begin
            out_wait--;
            out_ch.ready <= (out_wait == 0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task send(logic m, logic [7:0] b, bit gaps);
        int g;
        g = gaps ? $urandom_range(0, 15) : 0;
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= '{mode: m, data_byte: b};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task send_msg(int len, int kind, bit gaps);
        for (int i = 0; i < len; i++) begin
            case (kind)
                0: send(sha256_pkg::MODE_DATA, 8'($urandom_range(0, 255)), gaps);
                1: send(sha256_pkg::MODE_DATA, 8'hff, gaps);
                default: send(sha256_pkg::MODE_DATA, 8'h00, gaps);
            endcase
        end
        send(sha256_pkg::MODE_FINISH, 8'($urandom_range(0, 255)), gaps);
        sent_msgs++;
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    initial begin
        int total;
        int len;
        in_ch.valid <= 1'b0;
        in_ch.payload <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: empty message, "abc", and the padding boundaries.
        send(sha256_pkg::MODE_FINISH, 8'h00, 0);
        send(sha256_pkg::MODE_DATA, 8'h61, 0);
        send(sha256_pkg::MODE_DATA, 8'h62, 0);
        send(sha256_pkg::MODE_DATA, 8'h63, 0);
        send(sha256_pkg::MODE_FINISH, 8'hff, 0);
        send_msg(1, 1, 0);
        send_msg(2, 2, 0);
        drain();
        send_msg(55, 0, 1);
        send_msg(56, 1, 0);
        send_msg(64, 0, 1);
        drain();
        total = 200;
        while (total < 370) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70)
                                              : $urandom_range(0, 12);
            if (total > 280) stall_mode = ($urandom_range(0, 3) != 0);
            send_msg(len, 0, $urandom_range(0, 3) != 0);
            total += len + 1;
        end
        stall_mode = 1'b1;
        drain();
        $display("covered %0d messages including empty, abc, 55/56/64-byte padding edges",
                 sent_msgs + 2);
        $display("%0d digest words checked", sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sha256_hash_engine_top regression: pass");
        else
            $display("sha256_hash_engine_top regression: fail");
        $finish;
    end
endmodule
